>>> hdl/averaging_channel_mixer_macros.svh
// assertion macros for the averaging channel mixer
// used by averaging_channel_mixer.sv; expects clk and rst_n in scope
`ifndef AVERAGING_CHANNEL_MIXER_MACROS_SVH
`define AVERAGING_CHANNEL_MIXER_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every edge outside reset
`define ACM_ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// consequent holds in the cycle after the antecedent
`define ACM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ACM_ASSERT_HOLDS(label, prop, msg)
`define ACM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> hdl/acm_pkg.sv
// shared types and constants for the averaging channel mixer
// no dependencies
package acm_pkg;

    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_MAX_SOURCES  = 16;
    localparam int DEF_SAMPLE_BITS  = 16;

    localparam int CHANNEL_COUNT_BITS = 4;
    localparam int SOURCE_COUNT_BITS  = 5;
    localparam int CHANNEL_BITS       = 3;
    localparam int CFG_DATA_BITS      = 5;
    localparam int CFG_INDEX_BITS     = 2;

    localparam logic [CHANNEL_COUNT_BITS-1:0] CHANNEL_COUNT_RESET = 4'd2;
    localparam logic [SOURCE_COUNT_BITS-1:0]  SOURCE_COUNT_RESET  = 5'd1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_COUNT  = 2'd1;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } acm_div_status_t;

endpackage

>>> hdl/acm_in_if.sv
// input sample channel: valid/ready handshake with one sample per item
// depends on acm_pkg
interface acm_in_if
    import acm_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

>>> hdl/acm_out_if.sv
// mixed output channel: valid/ready handshake with one averaged sample per item
// depends on acm_pkg
interface acm_out_if
    import acm_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mixed_sample;
    logic [CHANNEL_BITS-1:0]       channel;
    logic                          frame_end;

    modport source (output valid, output mixed_sample, output channel, output frame_end,
                    input ready);
    modport sink (input valid, input mixed_sample, input channel, input frame_end,
                  output ready);
endinterface

>>> hdl/acm_divider.sv
// serial restoring divider: signed sum over unsigned source count, toward zero
// one quotient bit per cycle; depends on acm_pkg
module acm_divider
    import acm_pkg::*;
#(
    parameter int MAX_SOURCES = DEF_MAX_SOURCES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic signed [SAMPLE_BITS+$clog2(MAX_SOURCES)-1:0] dividend,
    input  logic [$clog2(MAX_SOURCES+1)-1:0]          divisor,
    output logic signed [SAMPLE_BITS-1:0]             quotient,
    output acm_div_status_t                           status
);
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_SOURCES);
    localparam int SRC_BITS = $clog2(MAX_SOURCES + 1);
    localparam int CNT_BITS = $clog2(SUM_BITS + 1);

    logic                busy_reg, busy_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [SRC_BITS-1:0] rem_reg, rem_next;
    logic [SUM_BITS-1:0] quot_reg, quot_next;
    logic                neg_reg, neg_next;

    logic [SRC_BITS:0]   trial;
    logic [SUM_BITS-1:0] signed_quot;

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        neg_next   = neg_reg;
        trial      = {rem_reg, quot_reg[SUM_BITS-1]};
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CNT_BITS'(SUM_BITS);
            rem_next   = '0;
            neg_next   = dividend[SUM_BITS-1];
            // magnitude; the most negative sum maps onto its unsigned value
            quot_next  = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next  = SRC_BITS'(trial - {1'b0, divisor});
                quot_next = {quot_reg[SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[SRC_BITS-1:0];
                quot_next = {quot_reg[SUM_BITS-2:0], 1'b0};
            end
            count_next = count_reg - CNT_BITS'(1);
            if (count_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        neg_reg  <= neg_next;
    end

    assign signed_quot = neg_reg ? (~quot_reg + SUM_BITS'(1)) : quot_reg;
    assign quotient    = signed_quot[SAMPLE_BITS-1:0];
    assign status.busy = busy_reg;
    assign status.done = busy_reg && (count_reg == CNT_BITS'(1));
endmodule

>>> hdl/averaging_channel_mixer.sv
// averaging channel mixer top level: accumulators, frame sequencer, output register
// depends on acm_pkg, acm_in_if, acm_out_if, acm_divider and the macros header
//
// usage
// - src carries input items, one sample each, in frame order: every channel of
//   source 0, then every channel of source 1, and so on
// - mix carries one item per channel at the end of each frame, in channel order,
//   holding sum / source_count truncated toward zero; frame_end marks the last
// - cfg_we/cfg_index/cfg_data write channel_count (index 0) and source_count
//   (index 1); any write to either abandons the frame and clears all sums
// timing
// - an item that does not end a frame is taken while the sequencer stays idle
// - after a frame-ending item each channel in turn goes through load, divide and
//   push on the shared serial divider; src.ready stays low until the last average
//   is queued
// - reset clears every sum and both positions, channel_count = 2, source_count = 1
// - a stalled receiver holds the current result in the output register; the
//   divider result for the next channel waits until that register frees up
`include "averaging_channel_mixer_macros.svh"

module averaging_channel_mixer
    import acm_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_SOURCES  = DEF_MAX_SOURCES,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    acm_in_if.sink                    src,
    acm_out_if.source                 mix,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_SOURCES);
    localparam int SRC_BITS    = $clog2(MAX_SOURCES + 1);
    localparam int CH_CNT_BITS = $clog2(MAX_CHANNELS + 1);
    localparam int CH_IDX_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_PUSH
    } state_t;

    // sequencer state
    state_t                    state_reg, state_next;
    logic [CH_IDX_BITS-1:0]    ch_pos_reg, ch_pos_next;
    logic [SRC_BITS-1:0]       src_pos_reg, src_pos_next;
    logic [CH_IDX_BITS-1:0]    k_reg, k_next;

    // configuration
    logic [CHANNEL_COUNT_BITS-1:0] channel_count_reg;
    logic [SOURCE_COUNT_BITS-1:0]  source_count_reg;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic [CHANNEL_BITS-1:0]       out_channel_reg, out_channel_next;
    logic                          out_end_reg, out_end_next;

    // per-channel accumulators
    logic signed [SUM_BITS-1:0] sums_reg [MAX_CHANNELS];

    logic                          src_take;
    logic                          mix_take;
    logic                          cfg_hit;
    logic [CH_CNT_BITS-1:0]        eff_ch;
    logic [SRC_BITS-1:0]           eff_src;
    logic [CH_IDX_BITS-1:0]        rd_idx;
    logic signed [SUM_BITS-1:0]    sum_rd;
    logic signed [SUM_BITS-1:0]    sum_add;
    logic                          ch_last;
    logic                          src_last;
    logic                          k_last;
    logic                          div_start;
    logic signed [SAMPLE_BITS-1:0] div_quot;
    acm_div_status_t               div_status;

    assign src_take = src.valid && src.ready;
    assign mix_take = mix.valid && mix.ready;
    assign cfg_hit  = cfg_we && ((cfg_index == REG_CHANNEL_COUNT)
                               || (cfg_index == REG_SOURCE_COUNT));

    // effective counts: zero counts as one, large values saturate
    always_comb
    begin
        if (channel_count_reg == '0)
        begin
            eff_ch = CH_CNT_BITS'(1);
        end
        else if (32'(channel_count_reg) > 32'(MAX_CHANNELS))
        begin
            eff_ch = CH_CNT_BITS'(MAX_CHANNELS);
        end
        else
        begin
            eff_ch = CH_CNT_BITS'(channel_count_reg);
        end

        if (source_count_reg == '0)
        begin
            eff_src = SRC_BITS'(1);
        end
        else if (32'(source_count_reg) > 32'(MAX_SOURCES))
        begin
            eff_src = SRC_BITS'(MAX_SOURCES);
        end
        else
        begin
            eff_src = SRC_BITS'(source_count_reg);
        end
    end

    // single accumulator read port: input channel while idle, drain channel otherwise
    assign rd_idx  = (state_reg == ST_IDLE) ? ch_pos_reg : k_reg;
    assign sum_rd  = sums_reg[rd_idx];
    assign sum_add = sum_rd + SUM_BITS'(src.sample);

    assign ch_last  = (CH_CNT_BITS'(ch_pos_reg) + CH_CNT_BITS'(1)) == eff_ch;
    assign src_last = (src_pos_reg + SRC_BITS'(1)) == eff_src;
    assign k_last   = (CH_CNT_BITS'(k_reg) + CH_CNT_BITS'(1)) == eff_ch;

    assign div_start = (state_reg == ST_LOAD);

    acm_divider #(
        .MAX_SOURCES (MAX_SOURCES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_rd),
        .divisor  (eff_src),
        .quotient (div_quot),
        .status   (div_status)
    );

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        ch_pos_next      = ch_pos_reg;
        src_pos_next     = src_pos_reg;
        k_next           = k_reg;
        out_valid_next   = out_valid_reg && !mix_take;
        out_sample_next  = out_sample_reg;
        out_channel_next = out_channel_reg;
        out_end_next     = out_end_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_hit)
                begin
                    // frame abandoned
                    ch_pos_next  = '0;
                    src_pos_next = '0;
                end
                else if (src_take)
                begin
                    if (!ch_last)
                    begin
                        ch_pos_next = ch_pos_reg + CH_IDX_BITS'(1);
                    end
                    else
                    begin
                        ch_pos_next = '0;
                        if (!src_last)
                        begin
                            src_pos_next = src_pos_reg + SRC_BITS'(1);
                        end
                        else
                        begin
                            // frame complete: drain every channel through the divider
                            src_pos_next = '0;
                            k_next       = '0;
                            state_next   = ST_LOAD;
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                // wait for a free output register
                if (!out_valid_reg || mix_take)
                begin
                    out_valid_next   = 1'b1;
                    out_sample_next  = div_quot;
                    out_channel_next = CHANNEL_BITS'(k_reg);
                    out_end_next     = k_last;
                    if (k_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CH_IDX_BITS'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            ch_pos_reg        <= '0;
            src_pos_reg       <= '0;
            k_reg             <= '0;
            out_valid_reg     <= 1'b0;
            channel_count_reg <= CHANNEL_COUNT_RESET;
            source_count_reg  <= SOURCE_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            ch_pos_reg    <= ch_pos_next;
            src_pos_reg   <= src_pos_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == REG_CHANNEL_COUNT))
            begin
                channel_count_reg <= cfg_data[CHANNEL_COUNT_BITS-1:0];
            end
            if (cfg_we && (cfg_index == REG_SOURCE_COUNT))
            begin
                source_count_reg <= cfg_data[SOURCE_COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_sample_reg  <= out_sample_next;
        out_channel_reg <= out_channel_next;
        out_end_reg     <= out_end_next;
    end

    // accumulators: cleared on reset and config writes, drained channel cleared on load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (cfg_hit)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (src_take)
        begin
            sums_reg[ch_pos_reg] <= sum_add;
        end
        else if (state_reg == ST_LOAD)
        begin
            sums_reg[k_reg] <= '0;
        end
    end

    assign src.ready        = (state_reg == ST_IDLE);
    assign mix.valid        = out_valid_reg;
    assign mix.mixed_sample = out_sample_reg;
    assign mix.channel      = out_channel_reg;
    assign mix.frame_end    = out_end_reg;

    // a frame-ending item hands control to the drain sequence
    `ACM_ASSERT_NEXT(a_frame_end_blocks_input, src_take && ch_last && src_last && !cfg_hit, !src.ready, "input still ready after frame end")
    // the divider finishes only while the sequencer waits for it
    `ACM_ASSERT_HOLDS(a_div_done_in_div, div_status.done |-> (state_reg == ST_DIV), "divider done outside wait state")
    // input is never taken while the divider runs
    `ACM_ASSERT_HOLDS(a_ready_divider_idle, src.ready |-> !div_status.busy, "input ready while divider busy")
    // a push with a free output register always produces an item
    `ACM_ASSERT_NEXT(a_push_fills_output, (state_reg == ST_PUSH) && (!mix.valid || mix.ready), mix.valid, "push lost a result")
endmodule

>>> dv/averaging_channel_mixer_checker.sv
// watches the sample and mix channels of the averaging channel mixer, predicts the averages
// and compares every mixed item against them; depends on acm_pkg, acm_in_if and acm_out_if
module averaging_channel_mixer_checker
    import acm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    acm_in_if                         src,
    acm_out_if                        mix,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        error_count,
    output int                        pending_count
);

    typedef struct packed {
        logic signed [15:0] mixed_sample;
        logic [2:0]         channel;
        logic               frame_end;
    } mix_result_t;

    logic [CHANNEL_COUNT_BITS-1:0] chan_count_reg;
    logic [SOURCE_COUNT_BITS-1:0]  src_count_reg;
    logic signed [19:0]            chan_sums [8];
    logic [2:0]                    chan_pos;
    logic [3:0]                    src_pos;
    mix_result_t                   averages_due [$];

    initial error_count = 0;

    function automatic int active_channels();
        if (chan_count_reg == 0) return 1;
        if (chan_count_reg > 8) return 8;
        return int'(chan_count_reg);
    endfunction

    function automatic int active_sources();
        if (src_count_reg == 0) return 1;
        if (src_count_reg > 16) return 16;
        return int'(src_count_reg);
    endfunction

    function automatic void clear_frame();
        foreach (chan_sums[i]) chan_sums[i] = '0;
        chan_pos = '0;
        src_pos  = '0;
    endfunction

    // adds one sample; at the end of a frame queues one average per channel
    function automatic void accumulate_sample(input logic signed [15:0] s);
        int          nch;
        int          nsrc;
        int          ch;
        int          avg;
        mix_result_t r;
        nch  = active_channels();
        nsrc = active_sources();
        ch   = int'(chan_pos);
        if (ch >= nch) ch = 0;
        chan_sums[ch] = chan_sums[ch] + s;
        ch++;
        if (ch < nch) begin
            chan_pos = ch[2:0];
            return;
        end
        chan_pos = '0;
        if (int'(src_pos) + 1 < nsrc) begin
            src_pos = src_pos + 4'd1;
            return;
        end
        src_pos = '0;
        for (int k = 0; k < nch; k++) begin
            avg            = int'(chan_sums[k]) / nsrc;
            r.mixed_sample = avg[15:0];
            r.channel      = k[2:0];
            r.frame_end    = (k == nch - 1);
            averages_due.push_back(r);
            chan_sums[k] = '0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mix_result_t want;
        if (!rst_n)
        begin
            chan_count_reg = CHANNEL_COUNT_RESET;
            src_count_reg  = SOURCE_COUNT_RESET;
            clear_frame();
            averages_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_CHANNEL_COUNT)
                begin
                    chan_count_reg = cfg_data[CHANNEL_COUNT_BITS-1:0];
                    clear_frame();
                end
                else if (cfg_index == REG_SOURCE_COUNT)
                begin
                    src_count_reg = cfg_data;
                    clear_frame();
                end
            end
            if (src.valid && src.ready)
                accumulate_sample(src.sample);
            if (mix.valid && mix.ready)
            begin
                if (averages_due.size() == 0)
                    report_mismatch("unexpected item on channel", int'(mix.channel), -1);
                else
                begin
                    want = averages_due.pop_front();
                    if (mix.mixed_sample !== want.mixed_sample)
                        report_mismatch("mixed_sample", int'(mix.mixed_sample),
                                        int'(want.mixed_sample));
                    if (mix.channel !== want.channel)
                        report_mismatch("channel", int'(mix.channel), int'(want.channel));
                    if (mix.frame_end !== want.frame_end)
                        report_mismatch("frame_end", int'(mix.frame_end),
                                        int'(want.frame_end));
                end
            end
        end
        pending_count = averages_due.size();
    end

endmodule

>>> dv/averaging_channel_mixer_test.sv
// top of the averaging channel mixer testbench: clock, reset, sample and register stimulus,
// receiver stalls and the verdict; depends on acm_pkg, both channel interfaces, the mixer
// and averaging_channel_mixer_checker
module averaging_channel_mixer_test;
    import acm_pkg::*;

    // unmapped register indexes, writes there must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_3 = 2'd3;
    // worst divider run for a full frame of 8 channels, plus margin
    localparam int SETTLE_CYCLES = 8 * 22 + 16;
    // long receiver stall, well beyond one full frame of averages
    localparam int LONG_HOLD_CYCLES = 300;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int                        errors;
    int                        pending;

    // idling modes, redrawn per phase; a burst side draws no random gaps
    bit send_burst;
    bit take_burst;
    int long_hold;

    acm_in_if  src_if ();
    acm_out_if mix_if ();

    averaging_channel_mixer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src       (src_if),
        .mix       (mix_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    averaging_channel_mixer_checker mix_predictor (
        .clk           (clk),
        .rst_n         (rst_n),
        .src           (src_if),
        .mix           (mix_if),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (errors),
        .pending_count (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #2000000;
        $display("averaging_channel_mixer_test: done, errors");
        $finish;
    end

    function automatic int draw_gap(input bit burst);
        if (burst) return 0;
        return $urandom_range(0, 13);
    endfunction

    // extremes and small values turn up often, the rest is uniform
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // offers one sample item after a random gap unless send_burst is set; called and returns at a falling edge,
    // valid is left high so that a back-to-back item follows with no drop in valid
    task automatic push_sample(input logic signed [15:0] s);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            src_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_if.sample <= s;
        src_if.valid  <= 1'b1;
        do @(posedge clk); while (!src_if.ready);
        @(negedge clk);
    endtask

    // drops valid, waits for every average to come back, then lets the divider go quiet
    task automatic settle();
        src_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one register write; drops cfg_we again before returning so that back-to-back writes never clash
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // receiver: a random hold-off before each item, plus the long stall when asked
    initial
    begin
        int gap;
        mix_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (long_hold > 0)
            begin
                mix_if.ready <= 1'b0;
                repeat (long_hold) @(negedge clk);
                long_hold = 0;
            end
            gap = draw_gap(take_burst);
            if (gap > 0)
            begin
                mix_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            mix_if.ready <= 1'b1;
            do @(posedge clk); while (!mix_if.valid);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [CFG_DATA_BITS-1:0] cc;
        logic [CFG_DATA_BITS-1:0] sc;
        int                       nch;
        int                       nsrc;
        int                       frame_len;
        int                       nframes;
        int                       tail;
        int                       fill;
        int                       sent;
        int                       phase;
        logic signed [15:0]       s;

        // every input known from time zero
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        src_if.valid  = 1'b0;
        src_if.sample = '0;
        send_burst    = 1'b0;
        take_burst    = 1'b0;
        long_hold     = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset setting: two channels, one source, full-scale samples pass straight through
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        settle();

        // zero counts behave as one
        write_reg(REG_CHANNEL_COUNT, 5'd0);
        write_reg(REG_SOURCE_COUNT, 5'd0);
        push_sample(16'shffff);
        settle();

        // channel count above the maximum saturates to eight
        write_reg(REG_CHANNEL_COUNT, 5'd15);
        write_reg(REG_SOURCE_COUNT, 5'd1);
        for (int i = 0; i < 8; i++)
            push_sample(i[0] ? 16'sh8000 : 16'sh7fff);
        settle();

        // negative average truncates toward zero: -3 / 2 is -1
        write_reg(REG_CHANNEL_COUNT, 5'd1);
        write_reg(REG_SOURCE_COUNT, 5'd2);
        push_sample(-16'sd3);
        push_sample(16'sd0);
        settle();

        // a write to an unmapped index leaves the half-done frame alone
        write_reg(REG_CHANNEL_COUNT, 5'd2);
        push_sample(16'sd5);
        settle();
        write_reg(REG_UNMAPPED_3, 5'd31);
        for (int i = 0; i < 3; i++)
            push_sample(pick_sample());
        settle();

        // rewriting the same value still abandons the frame in progress
        push_sample(16'sd7);
        settle();
        write_reg(REG_SOURCE_COUNT, 5'd2);
        write_reg(REG_UNMAPPED_2, 5'd10);
        for (int i = 0; i < 4; i++)
            push_sample(pick_sample());

        // random phases: new counts, whole frames of random content, now and then a
        // broken frame that the next register write throws away
        sent  = 0;
        phase = 0;
        while (sent < 180 || phase < 3)
        begin
            settle();
            if ($urandom_range(0, 4) == 0)
                cc = CFG_DATA_BITS'($urandom_range(0, 15));
            else
                cc = CFG_DATA_BITS'($urandom_range(1, 8));
            if ($urandom_range(0, 7) == 0)
                sc = CFG_DATA_BITS'($urandom_range(0, 31));
            else
                sc = CFG_DATA_BITS'($urandom_range(1, 4));
            send_burst = ($urandom_range(0, 3) == 0);
            take_burst = ($urandom_range(0, 3) == 0);
            nframes    = $urandom_range(1, 4);
            if (phase == 0)
            begin
                // source count above the maximum saturates to sixteen
                cc = 5'd1;
                sc = 5'd31;
            end
            else if (phase == 2)
            begin
                // receiver stalls for a long stretch while the sender keeps offering
                // frames, so the output register and the divider back up into src
                cc         = 5'd8;
                sc         = 5'd1;
                nframes    = 3;
                send_burst = 1'b1;
                long_hold  = LONG_HOLD_CYCLES;
            end
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(REG_CHANNEL_COUNT, cc);
                write_reg(REG_SOURCE_COUNT, sc);
            end
            else
            begin
                write_reg(REG_SOURCE_COUNT, sc);
                write_reg(REG_CHANNEL_COUNT, cc);
            end

            // frame length follows the effective counts
            nch       = (cc[3:0] == 0) ? 1 : (cc[3:0] > 8) ? 8 : int'(cc[3:0]);
            nsrc      = (sc == 0) ? 1 : (sc > 16) ? 16 : int'(sc);
            frame_len = nch * nsrc;
            if (frame_len > 32)
                nframes = 1;
            tail = 0;
            if (frame_len > 1 && phase != 2 && $urandom_range(0, 3) == 0)
                tail = $urandom_range(1, frame_len - 1);

            // some phases hold one extreme throughout to reach the largest sums
            fill = $urandom_range(0, 5);
            for (int i = 0; i < nframes * frame_len + tail; i++)
            begin
                case (fill)
                    0:       s = 16'sh7fff;
                    1:       s = 16'sh8000;
                    default: s = pick_sample();
                endcase
                push_sample(s);
            end
            sent  += nframes * frame_len + tail;
            phase += 1;
        end

        // drain and give the verdict
        src_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending != 0)
            $display("%0d expected mixed items never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("averaging_channel_mixer_test: done, clean");
        else
            $display("averaging_channel_mixer_test: done, errors");
        $finish;
    end

endmodule
